[design/radix64_stream_codec_defines.svh]
// Assertion macros used by the radix-64 codec RTL.
`ifndef RADIX64_STREAM_CODEC_DEFINES_SVH
`define RADIX64_STREAM_CODEC_DEFINES_SVH

`ifndef ASSERT_OFF
`define RSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define RSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RSC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/rsc_pkg.sv]
// Package with the types, codes and symbol mapping functions of the radix-64 codec.
package rsc_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int BYTE_W = 8;
  localparam int LIMIT_W = 16;
  localparam int STATUS_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int MAX_RESULTS = 5;
  localparam int RES_CNT_W = 3;

  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 16'hffff;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_OUT_LIMIT = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                out_kind;
    logic [STATUS_W-1:0] status;
    logic                out_last;
  } result_t;

  function automatic logic [BYTE_W-1:0] sym_char(input logic [5:0] idx);
    logic [BYTE_W-1:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      sym_char = 8'h41 + wide;
    end else if (idx < 6'd36) begin
      sym_char = 8'h30 + (wide - 8'd26);
    end else if (idx < 6'd62) begin
      sym_char = 8'h61 + (wide - 8'd36);
    end else if (idx == 6'd62) begin
      sym_char = 8'h2d;
    end else begin
      sym_char = 8'h5f;
    end
  endfunction

  // Returns a valid flag above the 6-bit symbol index.
  function automatic logic [6:0] sym_index(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
      sym_index = {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd26;
      sym_index = {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h61 + 8'd36;
      sym_index = {1'b1, d[5:0]};
    end else if (c == 8'h2d) begin
      sym_index = {1'b1, 6'd62};
    end else if (c == 8'h5f) begin
      sym_index = {1'b1, 6'd63};
    end else begin
      sym_index = {1'b0, d[5:0]};
    end
  endfunction

endpackage

[design/rsc_if.sv]
// Stream interfaces for the input items and result items of the codec.
interface rsc_in_if;
  logic                      valid;
  logic                      ready;
  logic [rsc_pkg::BYTE_W-1:0] in_byte;
  logic                      in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface rsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rsc_pkg::BYTE_W-1:0]   out_byte;
  logic                        out_kind;
  logic [rsc_pkg::STATUS_W-1:0] status;
  logic                        out_last;

  modport source (output valid, output out_byte, output out_kind, output status,
                  output out_last, input ready);
  modport sink (input valid, input out_byte, input out_kind, input status,
                input out_last, output ready);
endinterface

[design/radix64_stream_codec.sv]
// Radix-64 stream codec top level with input register, codec logic and result queue.
// An input item is registered in the input register; its results are then registered in the result queue.
// Throughput: one input item per cycle while the result queue is empty; results leave
// at one per cycle while dout.ready is high; the next item waits in the input register until
// the last queued result is popped, so sustained encoding is paced by the queue draining.
// Reset clears the message state, the input register, the result queue, direction to encode and out_limit to 65535.
`include "radix64_stream_codec_defines.svh"

module radix64_stream_codec #(
  parameter int COUNT_BITS = rsc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  rsc_in_if.sink                      din,
  rsc_out_if.source                   dout,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsc_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsc_pkg::DATA_W-1:0]  pwdata,
  output logic [rsc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int LW = ((COUNT_BITS > rsc_pkg::LIMIT_W) ? COUNT_BITS : rsc_pkg::LIMIT_W) + 1;
  localparam int NR = rsc_pkg::MAX_RESULTS;
  localparam int CW = rsc_pkg::RES_CNT_W;

  logic                          direction;
  logic [rsc_pkg::LIMIT_W-1:0]   out_limit;
  logic                          cfg_write;

  logic                          ir_valid;
  logic [rsc_pkg::BYTE_W-1:0]    ir_byte;
  logic                          ir_last;
  logic                          ir_adv;

  logic [23:0]                   group_value, group_value_next;
  logic [1:0]                    group_fill, group_fill_next;
  logic [COUNT_BITS-1:0]         written_count, written_count_next;
  logic                          halted, halted_next;
  logic                          overflow_seen, overflow_seen_next;
  logic                          bad_symbol_seen, bad_symbol_seen_next;

  logic [LW-1:0]                 lim_ext, cmax, lim, wc;
  logic [LW-1:0]                 enc_avail, dec_avail;
  logic [2:0]                    enc_k;
  logic [1:0]                    dec_m;
  logic [23:0]                   enc_acc, dec_acc;
  logic [6:0]                    sym_res;
  logic                          idx_ok;
  logic [5:0]                    idx;
  logic [rsc_pkg::BYTE_W-1:0]    dvals [4];

  logic [2:0]                    dcnt;
  logic                          tail_en;
  logic [rsc_pkg::STATUS_W-1:0]  tail_st;
  logic                          bad_all;
  logic                          trunc;
  logic [CW-1:0]                 res_n;
  rsc_pkg::result_t              res [NR];

  rsc_pkg::result_t              ob [NR];
  logic [CW-1:0]                 ob_cnt;
  logic                          pop;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= rsc_pkg::DIR_ENCODE;
      out_limit <= rsc_pkg::OUT_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        rsc_pkg::REG_DIRECTION: direction <= pwdata[0];
        rsc_pkg::REG_OUT_LIMIT: out_limit <= pwdata[rsc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rsc_pkg::REG_DIRECTION: prdata = {{(rsc_pkg::DATA_W-1){1'b0}}, direction};
      rsc_pkg::REG_OUT_LIMIT:
        prdata = {{(rsc_pkg::DATA_W-rsc_pkg::LIMIT_W){1'b0}}, out_limit};
      default: prdata = '0;
    endcase
  end

  // Handshakes.
  assign pop = dout.valid && dout.ready;
  assign ir_adv = ir_valid && ((ob_cnt == '0) || ((ob_cnt == CW'(1)) && pop));
  assign din.ready = !ir_valid || ir_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (din.ready) begin
      ir_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      ir_byte <= din.in_byte;
      ir_last <= din.in_last;
    end
  end

  // Capacity arithmetic.
  assign lim_ext = LW'(out_limit);
  assign cmax = LW'({COUNT_BITS{1'b1}});
  assign lim = (lim_ext > cmax) ? cmax : lim_ext;
  assign wc = LW'(written_count);
  assign enc_avail = (lim > wc + LW'(1)) ? (lim - wc - LW'(1)) : '0;
  assign enc_k = (enc_avail >= LW'(4)) ? 3'd4 : enc_avail[2:0];
  assign dec_avail = (lim > wc) ? (lim - wc) : '0;
  assign dec_m = (dec_avail >= LW'(3)) ? 2'd3 : dec_avail[1:0];

  // Group accumulation.
  assign sym_res = rsc_pkg::sym_index(ir_byte);
  assign idx_ok = sym_res[6];
  assign idx = sym_res[5:0];

  always_comb begin
    unique case (group_fill)
      2'd0: enc_acc = group_value | {16'b0, ir_byte};
      2'd1: enc_acc = group_value | {8'b0, ir_byte, 8'b0};
      2'd2: enc_acc = group_value | {ir_byte, 16'b0};
      default: enc_acc = group_value;
    endcase
  end

  always_comb begin
    dec_acc = group_value;
    if (idx_ok) begin
      unique case (group_fill)
        2'd0: dec_acc = group_value | {18'b0, idx};
        2'd1: dec_acc = group_value | {12'b0, idx, 6'b0};
        2'd2: dec_acc = group_value | {6'b0, idx, 12'b0};
        default: dec_acc = group_value | {idx, 18'b0};
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (direction == rsc_pkg::DIR_ENCODE) begin
        dvals[j] = rsc_pkg::sym_char(enc_acc[6*j +: 6]);
      end else if (j < 3) begin
        dvals[j] = dec_acc[8*j +: 8];
      end else begin
        dvals[j] = '0;
      end
    end
  end

  // Result selection and message state update.
  always_comb begin
    dcnt = 3'd0;
    tail_en = 1'b0;
    tail_st = rsc_pkg::STATUS_OK;
    trunc = 1'b0;
    bad_all = bad_symbol_seen || !idx_ok;
    group_value_next = group_value;
    group_fill_next = group_fill;
    written_count_next = written_count;
    halted_next = halted;
    overflow_seen_next = overflow_seen;
    bad_symbol_seen_next = bad_symbol_seen;

    if (halted) begin
      dcnt = 3'd0;
    end else if (direction == rsc_pkg::DIR_ENCODE) begin
      if (group_fill >= 2'd2 || ir_last) begin
        trunc = (enc_k != 3'd4);
        dcnt = enc_k;
        tail_en = trunc || ir_last;
        tail_st = trunc ? rsc_pkg::STATUS_OVERFLOW : rsc_pkg::STATUS_OK;
        group_value_next = '0;
        group_fill_next = 2'd0;
        written_count_next = written_count + COUNT_BITS'(enc_k);
        halted_next = trunc;
      end else begin
        group_value_next = enc_acc;
        group_fill_next = group_fill + 2'd1;
      end
    end else begin
      if (group_fill == 2'd3) begin
        if (bad_all) begin
          tail_en = 1'b1;
          tail_st = rsc_pkg::STATUS_INVALID;
          halted_next = 1'b1;
        end else begin
          dcnt = {1'b0, dec_m};
          written_count_next = written_count + COUNT_BITS'(dec_m);
          overflow_seen_next = overflow_seen || (dec_m != 2'd3);
        end
        group_value_next = '0;
        group_fill_next = 2'd0;
        bad_symbol_seen_next = 1'b0;
      end else begin
        group_value_next = dec_acc;
        group_fill_next = group_fill + 2'd1;
        bad_symbol_seen_next = bad_all;
      end
      if (!halted_next && ir_last) begin
        tail_en = 1'b1;
        tail_st = overflow_seen_next ? rsc_pkg::STATUS_OVERFLOW : rsc_pkg::STATUS_OK;
      end
    end

    if (ir_last) begin
      group_value_next = '0;
      group_fill_next = 2'd0;
      written_count_next = '0;
      halted_next = 1'b0;
      overflow_seen_next = 1'b0;
      bad_symbol_seen_next = 1'b0;
    end
  end

  assign res_n = CW'(dcnt) + CW'(tail_en);

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      res[j] = '0;
      if (j < 4 && CW'(j) < CW'(dcnt)) begin
        res[j].out_byte = dvals[j % 4];
        res[j].out_kind = rsc_pkg::KIND_DATA;
        res[j].status = rsc_pkg::STATUS_OK;
        res[j].out_last = 1'b0;
      end else if (CW'(j) == CW'(dcnt) && tail_en) begin
        res[j].out_byte = '0;
        res[j].out_kind = rsc_pkg::KIND_END;
        res[j].status = tail_st;
        res[j].out_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_value <= '0;
      group_fill <= 2'd0;
      written_count <= '0;
      halted <= 1'b0;
      overflow_seen <= 1'b0;
      bad_symbol_seen <= 1'b0;
    end else if (ir_adv) begin
      group_value <= group_value_next;
      group_fill <= group_fill_next;
      written_count <= written_count_next;
      halted <= halted_next;
      overflow_seen <= overflow_seen_next;
      bad_symbol_seen <= bad_symbol_seen_next;
    end
  end

  // Result queue: loaded whole, drained from the head.
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= '0;
    end else if (ir_adv) begin
      ob_cnt <= res_n;
    end else if (pop) begin
      ob_cnt <= ob_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ir_adv) begin
      ob <= res;
    end else if (pop) begin
      for (int j = 0; j < NR - 1; j++) begin
        ob[j] <= ob[j+1];
      end
    end
  end

  assign dout.valid = (ob_cnt != '0);
  assign dout.out_byte = ob[0].out_byte;
  assign dout.out_kind = ob[0].out_kind;
  assign dout.status = ob[0].status;
  assign dout.out_last = ob[0].out_last;

  `RSC_ASSERT_IMPLY(a_halt_clean, clk, rst, halted, group_fill == 2'd0 && group_value == '0)
  `RSC_ASSERT_NEXT(a_ir_hold, clk, rst, ir_valid && !ir_adv, ir_valid && ir_byte == $past(ir_byte) && ir_last == $past(ir_last))
  `RSC_ASSERT_NEXT(a_queue_load, clk, rst, ir_adv, ob_cnt == $past(res_n))
  `RSC_ASSERT_IMPLY(a_end_is_last, clk, rst, dout.valid && dout.out_kind == rsc_pkg::KIND_END, dout.out_last)

endmodule
